>>> design/bcv_pkg.sv
package bcv_pkg;

  // parameter t, unsigned Q1.16 (17 bits), so 1.0 fits
  localparam int unsigned T_W    = 17;
  localparam int unsigned T_FRAC = 16;
  localparam logic [T_W-1:0] T_ONE      = 17'd65536;
  localparam logic [T_W-1:0] T_STEP_RST = 17'd1040;

  localparam int unsigned IDX_W = 6;

  // APB register map: one 32-bit word per register
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam int unsigned REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_T_STEP = 1'b0;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

endpackage

>>> design/bcv_if.sv
interface bcv_in_if #(
  parameter int COORD_BITS = 16
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] x_ctrl_0;
  logic signed [COORD_BITS-1:0] x_ctrl_1;
  logic signed [COORD_BITS-1:0] x_ctrl_2;
  logic signed [COORD_BITS-1:0] x_ctrl_3;
  logic signed [COORD_BITS-1:0] y_ctrl_0;
  logic signed [COORD_BITS-1:0] y_ctrl_1;
  logic signed [COORD_BITS-1:0] y_ctrl_2;
  logic signed [COORD_BITS-1:0] y_ctrl_3;
  logic signed [COORD_BITS-1:0] z_ctrl_0;
  logic signed [COORD_BITS-1:0] z_ctrl_1;
  logic signed [COORD_BITS-1:0] z_ctrl_2;
  logic signed [COORD_BITS-1:0] z_ctrl_3;

  modport source (
    output valid,
    output x_ctrl_0, x_ctrl_1, x_ctrl_2, x_ctrl_3,
    output y_ctrl_0, y_ctrl_1, y_ctrl_2, y_ctrl_3,
    output z_ctrl_0, z_ctrl_1, z_ctrl_2, z_ctrl_3,
    input  ready
  );

  modport sink (
    input  valid,
    input  x_ctrl_0, x_ctrl_1, x_ctrl_2, x_ctrl_3,
    input  y_ctrl_0, y_ctrl_1, y_ctrl_2, y_ctrl_3,
    input  z_ctrl_0, z_ctrl_1, z_ctrl_2, z_ctrl_3,
    output ready
  );
endinterface

interface bcv_out_if #(
  parameter int COORD_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_BITS-1:0]  x_point;
  logic signed [COORD_BITS-1:0]  y_point;
  logic signed [COORD_BITS-1:0]  z_point;
  logic [bcv_pkg::IDX_W-1:0]     point_index;
  logic                          last_point;

  modport source (
    output valid,
    output x_point, y_point, z_point, point_index, last_point,
    input  ready
  );

  modport sink (
    input  valid,
    input  x_point, y_point, z_point, point_index, last_point,
    output ready
  );
endinterface

>>> design/bcv_seq.sv
module bcv_seq #(
  parameter int COORD_BITS = 16,
  parameter int MAX_POINTS = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  bcv_in_if.sink                          in_i,
  input  logic [bcv_pkg::T_W-1:0]         t_step_i,
  input  logic                            take_i,
  output logic                            valid_o,
  output logic [bcv_pkg::T_W-1:0]         t_o,
  output logic [$clog2(MAX_POINTS)-1:0]   k_o,
  output logic                            last_o,
  output logic signed [COORD_BITS+3:0]    a_o [3],
  output logic signed [COORD_BITS+3:0]    b_o [3],
  output logic signed [COORD_BITS+3:0]    c_o [3],
  output logic signed [COORD_BITS-1:0]    d_o [3]
);

  localparam int KW  = COORD_BITS + 4;
  localparam int IW  = $clog2(MAX_POINTS);
  localparam int SW  = bcv_pkg::T_W + 2;
  localparam logic signed [KW-1:0] K3 = KW'(3);
  localparam logic [IW-1:0] K_LAST = IW'(MAX_POINTS - 1);

  logic                    v_q, v_d;
  logic                    last_q, last_d;
  logic [bcv_pkg::T_W-1:0] t_q, t_d;
  logic [IW-1:0]           k_q, k_d;
  logic signed [KW-1:0]    a_q [3];
  logic signed [KW-1:0]    b_q [3];
  logic signed [KW-1:0]    c_q [3];
  logic signed [COORD_BITS-1:0] d_q [3];

  logic signed [COORD_BITS-1:0] p [3][4];
  logic signed [KW-1:0]    p0 [3];
  logic signed [KW-1:0]    p1 [3];
  logic signed [KW-1:0]    p2 [3];
  logic signed [KW-1:0]    p3 [3];

  logic                    load;
  logic                    adv;
  logic [bcv_pkg::T_W-1:0] t_nxt;
  logic [IW-1:0]           k_nxt;
  logic [SW-1:0]           t_ahead;

  assign p[0] = '{in_i.x_ctrl_0, in_i.x_ctrl_1, in_i.x_ctrl_2, in_i.x_ctrl_3};
  assign p[1] = '{in_i.y_ctrl_0, in_i.y_ctrl_1, in_i.y_ctrl_2, in_i.y_ctrl_3};
  assign p[2] = '{in_i.z_ctrl_0, in_i.z_ctrl_1, in_i.z_ctrl_2, in_i.z_ctrl_3};

  always_comb begin
    for (int ci = 0; ci < 3; ci++) begin
      p0[ci] = KW'(p[ci][0]);
      p1[ci] = KW'(p[ci][1]);
      p2[ci] = KW'(p[ci][2]);
      p3[ci] = KW'(p[ci][3]);
    end
  end

  assign in_i.ready = !v_q || (take_i && last_q);
  assign load       = in_i.valid && in_i.ready;
  assign adv        = v_q && take_i && !last_q;

  // t stays within 1.0 while the current point is not the last
  assign t_nxt   = t_q + t_step_i;
  assign k_nxt   = k_q + IW'(1);
  assign t_ahead = SW'(t_nxt) + SW'(t_step_i);

  always_comb begin
    v_d    = v_q;
    t_d    = t_q;
    k_d    = k_q;
    last_d = last_q;
    if (load) begin
      v_d    = 1'b1;
      t_d    = '0;
      k_d    = '0;
      last_d = t_step_i > bcv_pkg::T_ONE;
    end else if (adv) begin
      t_d    = t_nxt;
      k_d    = k_nxt;
      last_d = (k_nxt == K_LAST) || (t_ahead > SW'(bcv_pkg::T_ONE));
    end else if (v_q && take_i) begin
      v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= 1'b0;
      last_q <= 1'b0;
      t_q    <= '0;
      k_q    <= '0;
    end else begin
      v_q    <= v_d;
      last_q <= last_d;
      t_q    <= t_d;
      k_q    <= k_d;
    end
  end

  // power-basis coefficients from the Bezier basis matrix
  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int ci = 0; ci < 3; ci++) begin
        a_q[ci] <= p3[ci] - p0[ci] + K3 * (p1[ci] - p2[ci]);
        b_q[ci] <= K3 * (p0[ci] - (p1[ci] <<< 1) + p2[ci]);
        c_q[ci] <= K3 * (p1[ci] - p0[ci]);
        d_q[ci] <= p[ci][0];
      end
    end
  end

  assign valid_o = v_q;
  assign t_o     = t_q;
  assign k_o     = k_q;
  assign last_o  = last_q;
  assign a_o     = a_q;
  assign b_o     = b_q;
  assign c_o     = c_q;
  assign d_o     = d_q;

endmodule

>>> design/bcv_lane.sv
module bcv_lane #(
  parameter int COORD_BITS = 16
) (
  input  logic                          clk_i,
  input  bcv_pkg::stage_en_t            en_i,
  input  logic [bcv_pkg::T_W-1:0]       t_i,
  input  logic signed [COORD_BITS+3:0]  a_i,
  input  logic signed [COORD_BITS+3:0]  b_i,
  input  logic signed [COORD_BITS+3:0]  c_i,
  input  logic signed [COORD_BITS-1:0]  d_i,
  output logic signed [COORD_BITS-1:0]  p_o
);

  localparam int KW  = COORD_BITS + 4;
  localparam int TW  = bcv_pkg::T_W + 1;
  localparam int H1W = COORD_BITS + 21;
  localparam int H2W = COORD_BITS + 39;
  localparam int H3W = COORD_BITS + 57;
  localparam int RS  = 3 * bcv_pkg::T_FRAC;
  localparam int RW  = H3W - RS;
  localparam logic signed [H3W-1:0] RND = H3W'(1) <<< (RS - 1);
  localparam logic signed [RW-1:0] MAXR =
    {{(RW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [RW-1:0] MINR = ~MAXR;

  logic signed [TW-1:0]         ts0, ts1, ts2;
  logic [bcv_pkg::T_W-1:0]      t1_q, t2_q;
  logic signed [KW-1:0]         c1_q;
  logic signed [COORD_BITS-1:0] d1_q, d2_q;
  logic signed [H1W-1:0]        h1_q, h1_d;
  logic signed [H2W-1:0]        h2_q, h2_d;
  logic signed [H3W-1:0]        h3_q, h3_d;
  logic signed [H3W-1:0]        rsum;
  logic signed [RW-1:0]         r;
  logic signed [COORD_BITS-1:0] p_q, p_d;

  assign ts0 = $signed({1'b0, t_i});
  assign ts1 = $signed({1'b0, t1_q});
  assign ts2 = $signed({1'b0, t2_q});

  // Horner: ((a*t + b) * t + c) * t + d, exact in Q.48
  assign h1_d = a_i * ts0 + (H1W'(b_i) <<< bcv_pkg::T_FRAC);
  assign h2_d = h1_q * ts1 + (H2W'(c1_q) <<< (2 * bcv_pkg::T_FRAC));
  assign h3_d = h2_q * ts2 + (H3W'(d2_q) <<< RS);

  // round half up, then clamp
  assign rsum = h3_q + RND;
  assign r    = RW'(rsum >>> RS);

  always_comb begin
    if (r > MAXR) begin
      p_d = MAXR[COORD_BITS-1:0];
    end else if (r < MINR) begin
      p_d = MINR[COORD_BITS-1:0];
    end else begin
      p_d = r[COORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      h1_q <= h1_d;
      t1_q <= t_i;
      c1_q <= c_i;
      d1_q <= d_i;
    end
    if (en_i.s2) begin
      h2_q <= h2_d;
      t2_q <= t1_q;
      d2_q <= d1_q;
    end
    if (en_i.s3) begin
      h3_q <= h3_d;
    end
    if (en_i.s4) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

>>> design/cubic_bezier_curve_eval.sv
// Cubic Bezier evaluator: one curve point leaves per cycle while out_o.ready is high.
// An accepted control-point word passes the point sequencer, then four Horner/round
// stages (the last one the output register) before its first point leaves.
// A curve yields n points (n <= MAX_POINTS); the next curve is accepted in the cycle
// the sequencer passes its predecessor's last point into the first stage.
// Reset (rst_ni low, async): pipeline emptied, t_step back to 1040.
module cubic_bezier_curve_eval #(
  parameter int COORD_BITS = 16,
  parameter int MAX_POINTS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bcv_in_if.sink                        in_i,
  bcv_out_if.source                     out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bcv_pkg::APB_AW-1:0]    paddr,
  input  logic [bcv_pkg::APB_DW-1:0]    pwdata,
  output logic [bcv_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  localparam int KW = COORD_BITS + 4;
  localparam int IW = $clog2(MAX_POINTS);

  logic [bcv_pkg::T_W-1:0] t_step_q;
  logic [bcv_pkg::REG_IDX_W-1:0] reg_idx;
  logic                    cfg_wr;

  logic                    gen_v;
  logic                    gen_last;
  logic [bcv_pkg::T_W-1:0] gen_t;
  logic [IW-1:0]           gen_k;
  logic signed [KW-1:0]    coef_a [3];
  logic signed [KW-1:0]    coef_b [3];
  logic signed [KW-1:0]    coef_c [3];
  logic signed [COORD_BITS-1:0] coef_d [3];
  logic signed [COORD_BITS-1:0] pt [3];

  logic [3:0]              v_q;
  logic [3:0]              rdy;
  logic [IW-1:0]           k_q [4];
  logic [3:0]              last_q;
  bcv_pkg::stage_en_t      en;

  // APB register
  assign reg_idx = paddr[bcv_pkg::APB_AW-1 -: bcv_pkg::REG_IDX_W];
  assign cfg_wr  = psel && penable && pwrite && (reg_idx == bcv_pkg::REG_T_STEP);
  assign pready  = 1'b1;
  assign prdata  = (reg_idx == bcv_pkg::REG_T_STEP) ? bcv_pkg::APB_DW'(t_step_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_step_q <= bcv_pkg::T_STEP_RST;
    end else if (cfg_wr) begin
      t_step_q <= pwdata[bcv_pkg::T_W-1:0];
    end
  end

  // stage handshake: a stage loads when it is empty or drains this cycle
  assign rdy[3] = !v_q[3] || out_o.ready;
  assign rdy[2] = !v_q[2] || rdy[3];
  assign rdy[1] = !v_q[1] || rdy[2];
  assign rdy[0] = !v_q[0] || rdy[1];

  assign en.s1 = rdy[0];
  assign en.s2 = rdy[1];
  assign en.s3 = rdy[2];
  assign en.s4 = rdy[3];

  bcv_seq #(
    .COORD_BITS (COORD_BITS),
    .MAX_POINTS (MAX_POINTS)
  ) u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .t_step_i (t_step_q),
    .take_i   (rdy[0]),
    .valid_o  (gen_v),
    .t_o      (gen_t),
    .k_o      (gen_k),
    .last_o   (gen_last),
    .a_o      (coef_a),
    .b_o      (coef_b),
    .c_o      (coef_c),
    .d_o      (coef_d)
  );

  for (genvar ci = 0; ci < 3; ci++) begin : g_lane
    bcv_lane #(
      .COORD_BITS (COORD_BITS)
    ) u_lane (
      .clk_i (clk_i),
      .en_i  (en),
      .t_i   (gen_t),
      .a_i   (coef_a[ci]),
      .b_i   (coef_b[ci]),
      .c_i   (coef_c[ci]),
      .d_i   (coef_d[ci]),
      .p_o   (pt[ci])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= gen_v;
      if (rdy[1]) v_q[1] <= v_q[0];
      if (rdy[2]) v_q[2] <= v_q[1];
      if (rdy[3]) v_q[3] <= v_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      k_q[0]    <= gen_k;
      last_q[0] <= gen_last;
    end
    if (rdy[1]) begin
      k_q[1]    <= k_q[0];
      last_q[1] <= last_q[0];
    end
    if (rdy[2]) begin
      k_q[2]    <= k_q[1];
      last_q[2] <= last_q[1];
    end
    if (rdy[3]) begin
      k_q[3]    <= k_q[2];
      last_q[3] <= last_q[2];
    end
  end

  assign out_o.valid       = v_q[3];
  assign out_o.x_point     = pt[0];
  assign out_o.y_point     = pt[1];
  assign out_o.z_point     = pt[2];
  assign out_o.point_index = bcv_pkg::IDX_W'(k_q[3]);
  assign out_o.last_point  = last_q[3];

endmodule

>>> design/bcv_chk.sv
module bcv_chk #(
  parameter int COORD_BITS = 16,
  parameter int MAX_POINTS = 64
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [COORD_BITS-1:0]         x_point,
  input logic [bcv_pkg::IDX_W-1:0]     point_index,
  input logic                          last_point,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [bcv_pkg::APB_AW-1:0]    paddr,
  input logic [bcv_pkg::APB_DW-1:0]    pwdata
);

  localparam logic [bcv_pkg::IDX_W-1:0] IDX_LAST = bcv_pkg::IDX_W'(MAX_POINTS - 1);

  logic [bcv_pkg::IDX_W-1:0] exp_idx_q;
  logic [bcv_pkg::T_W-1:0]   step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_idx_q <= '0;
      step_q    <= bcv_pkg::T_STEP_RST;
    end else begin
      if (out_valid && out_ready) begin
        exp_idx_q <= last_point ? '0 : point_index + bcv_pkg::IDX_W'(1);
      end
      if (psel && penable && pwrite &&
          paddr[bcv_pkg::APB_AW-1 -: bcv_pkg::REG_IDX_W] == bcv_pkg::REG_T_STEP) begin
        step_q <= pwdata[bcv_pkg::T_W-1:0];
      end
    end
  end

  a_idx_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> point_index == exp_idx_q)
    else $error("point index out of sequence");

  a_idx_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && point_index == IDX_LAST |-> last_point)
    else $error("point count limit without last flag");

  a_big_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && step_q > bcv_pkg::T_ONE |-> last_point && point_index == '0)
    else $error("step above 1.0 must give a single point");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(x_point) && $stable(point_index)
      && $stable(last_point))
    else $error("stalled output word changed");

endmodule

bind cubic_bezier_curve_eval bcv_chk #(
  .COORD_BITS (COORD_BITS),
  .MAX_POINTS (MAX_POINTS)
) u_bcv_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .x_point     (out_o.x_point),
  .point_index (out_o.point_index),
  .last_point  (out_o.last_point),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata)
);
